### sv/pcsd_pkg.sv
// Shared types, codes and helpers for the pulse channel sweep/duty block.
`default_nettype none
package pcsd_pkg;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_TIMER = 2'd1;
	localparam logic [1:0] CMD_SWEEP = 2'd2;

	localparam logic [1:0] REG_DUTY      = 2'd0;
	localparam logic [1:0] REG_SWEEP     = 2'd1;
	localparam logic [1:0] REG_PERIOD_LO = 2'd2;
	localparam logic [1:0] REG_PERIOD_HI = 2'd3;

	localparam logic [11:0] PERIOD_MAX = 12'h7FF;
	localparam logic [10:0] PERIOD_MIN = 11'd8;

	localparam logic [7:0] DUTY_WORDS [4] = '{8'h80, 8'hC0, 8'hF0, 8'h3F};

	typedef struct packed {
		logic        duty_level;
		logic        muted;
		logic [11:0] timer_reload;
		logic        length_load;
		logic [4:0]  length_index;
		logic        envelope_restart;
		logic        envelope_write;
		logic [5:0]  envelope_bits;
	} result_t;

	// sweep target: period +/- (period >> shift), one extra off when negating on channel one
	function automatic logic [11:0] target_calc(input logic [10:0] period,
		input logic [2:0] shift, input logic down, input logic first);
		logic [11:0] p;
		logic [11:0] d;
		logic [11:0] t;
		p = {1'b0, period};
		d = p >> shift;
		if (down) begin
			t = p - d - {11'b0, first};
		end else begin
			t = p + d;
		end
		return t;
	endfunction

endpackage
`default_nettype wire

### sv/pcsd_core.sv
// Channel state and next-state/result logic for one request per cycle when step is asserted.
`default_nettype none
module pcsd_core
	import pcsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       step,
	input  wire logic [1:0] cmd,
	input  wire logic [1:0] reg_sel,
	input  wire logic [7:0] data,
	output result_t         res
);

	logic        first_q;
	logic [1:0]  duty_q, duty_n;
	logic [2:0]  pos_q, pos_n;
	logic [10:0] tone_q, tone_n;
	logic        on_q, on_n;
	logic        down_q, down_n;
	logic [3:0]  divp_q, divp_n;
	logic [2:0]  shift_q, shift_n;
	logic        pend_q, pend_n;
	logic [7:0]  cnt_q, cnt_n;
	logic [7:0]  cnt_dec;
	logic        fire;
	logic [11:0] target_cur;
	logic [11:0] target_nxt;
	logic [7:0]  duty_word;

	always_comb begin
		duty_n = duty_q;
		pos_n = pos_q;
		tone_n = tone_q;
		on_n = on_q;
		down_n = down_q;
		divp_n = divp_q;
		shift_n = shift_q;
		pend_n = pend_q;
		cnt_n = cnt_q;
		cnt_dec = cnt_q - 8'd1;
		fire = 1'b0;
		target_cur = target_calc(tone_q, shift_q, down_q, first_q);
		res.length_load = 1'b0;
		res.length_index = 5'd0;
		res.envelope_restart = 1'b0;
		res.envelope_write = 1'b0;
		res.envelope_bits = 6'd0;
		unique case (cmd)
			CMD_WRITE: begin
				unique case (reg_sel)
					REG_DUTY: begin
						duty_n = data[7:6];
						res.envelope_write = 1'b1;
						res.envelope_bits = data[5:0];
					end
					REG_SWEEP: begin
						on_n = data[7];
						divp_n = {1'b0, data[6:4]} + 4'd1;
						down_n = data[3];
						shift_n = data[2:0];
						pend_n = 1'b1;
					end
					REG_PERIOD_LO: begin
						tone_n = {tone_q[10:8], data};
					end
					REG_PERIOD_HI: begin
						tone_n = {data[2:0], tone_q[7:0]};
						pos_n = 3'd0;
						res.length_load = 1'b1;
						res.length_index = data[7:3];
						res.envelope_restart = 1'b1;
					end
					default: begin
					end
				endcase
			end
			CMD_TIMER: begin
				pos_n = pos_q - 3'd1;
			end
			CMD_SWEEP: begin
				cnt_n = cnt_dec;
				fire = (cnt_dec == 8'd0);
				if (fire && shift_q != 3'd0 && on_q && tone_q >= PERIOD_MIN
					&& target_cur <= PERIOD_MAX) begin
					tone_n = target_cur[10:0];
				end
				if (fire || pend_q) begin
					cnt_n = {4'd0, divp_q};
					pend_n = 1'b0;
				end
			end
			default: begin
			end
		endcase
		target_nxt = target_calc(tone_n, shift_n, down_n, first_q);
		duty_word = DUTY_WORDS[duty_n];
		res.muted = (tone_n < PERIOD_MIN) || (!down_n && target_nxt > PERIOD_MAX);
		res.duty_level = res.muted ? 1'b0 : duty_word[pos_n];
		res.timer_reload = {tone_n, 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (cfg_we) begin
			first_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= '0;
			pos_q <= '0;
			tone_q <= '0;
			on_q <= 1'b0;
			down_q <= 1'b0;
			divp_q <= '0;
			shift_q <= '0;
			pend_q <= 1'b0;
			cnt_q <= '0;
		end else if (step) begin
			duty_q <= duty_n;
			pos_q <= pos_n;
			tone_q <= tone_n;
			on_q <= on_n;
			down_q <= down_n;
			divp_q <= divp_n;
			shift_q <= shift_n;
			pend_q <= pend_n;
			cnt_q <= cnt_n;
		end
	end

`ifndef SYNTHESIS
	a_timer_steps_down: assert property (@(posedge clk) disable iff (!arst_n)
		step && cmd == CMD_TIMER |=> pos_q == 3'($past(pos_q) - 3'd1))
		else $error("sequencer did not step down");
	a_hi_write_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && cmd == CMD_WRITE && reg_sel == REG_PERIOD_HI |=> pos_q == 3'd0)
		else $error("sequencer not restarted on high period write");
	a_idle_holds_period: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(tone_q) && $stable(cnt_q))
		else $error("state changed without a request");
	a_reload_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		step && cmd == CMD_SWEEP |=> !pend_q)
		else $error("reload flag survived a sweep tick");
`endif

endmodule
`default_nettype wire

### sv/pcsd_out_reg.sv
// Result register with valid/ready handshake toward the receiver.
`default_nettype none
module pcsd_out_reg
	import pcsd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res_in,
	input  wire logic    out_ready,
	output logic         out_valid,
	output result_t      res_out
);

	logic    valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign out_valid = valid_q;
	assign res_out = res_q;

endmodule
`default_nettype wire

### sv/pulse_channel_sweep_duty.sv
// Top level of the pulse channel duty sequencer and frequency sweep.
//
// Requests enter on in_valid/in_ready carrying command, reg_index and
// write_data: a register write, a timer expiry or a sweep tick.
// Every request yields exactly one result on out_valid/out_ready with the
// gated duty bit, mute flag, timer reload and length/envelope strobes.
// A request is captured in an input register; when the result register is
// empty or being taken, the channel state is updated and the result register
// is loaded from that request in the same cycle.
// Throughput is one request per cycle while the receiver does not stall, set by the single state-update step.
// When the receiver stalls, the result register holds and the input
// register holds one more request; in_ready drops only while both are full.
// cfg_we/cfg_wdata write the channel-one select (negate subtracts one
// extra); it resets to 1 and must be written only while the block is idle.
// Reset clears all channel state: period 0, sequencer at step 0, sweep off.
`default_nettype none
module pulse_channel_sweep_duty
	import pcsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [1:0]  reg_index,
	input  wire logic [7:0]  write_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             duty_level,
	output logic             muted,
	output logic [11:0]      timer_reload,
	output logic             length_load,
	output logic [4:0]       length_index,
	output logic             envelope_restart,
	output logic             envelope_write,
	output logic [5:0]       envelope_bits
);

	logic       valid_s1;
	logic [1:0] command_s1;
	logic [1:0] reg_index_s1;
	logic [7:0] write_data_s1;
	logic       step;
	result_t    res_comb;
	result_t    res_reg;

	assign step = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			reg_index_s1 <= reg_index;
			write_data_s1 <= write_data;
		end
	end

	pcsd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.step     (step),
		.cmd      (command_s1),
		.reg_sel  (reg_index_s1),
		.data     (write_data_s1),
		.res      (res_comb)
	);

	pcsd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.res_in   (res_comb),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.res_out  (res_reg)
	);

	assign duty_level = res_reg.duty_level;
	assign muted = res_reg.muted;
	assign timer_reload = res_reg.timer_reload;
	assign length_load = res_reg.length_load;
	assign length_index = res_reg.length_index;
	assign envelope_restart = res_reg.envelope_restart;
	assign envelope_write = res_reg.envelope_write;
	assign envelope_bits = res_reg.envelope_bits;

`ifndef SYNTHESIS
	a_no_loss_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |-> !in_ready)
		else $error("request taken with no room");
	a_step_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid)
		else $error("result not registered after step");
`endif

endmodule
`default_nettype wire
